// ----- design/mawt_pkg.sv -----
// ----------------------------------------------------------------------------
// mawt_pkg
// Shared types, codes and decode functions for the bus access timing unit.
// ----------------------------------------------------------------------------
package mawt_pkg;

   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);

   // input kinds
   localparam logic [1:0] KIND_EXT = 2'd0;
   localparam logic [1:0] KIND_INT = 2'd1;
   localparam logic [1:0] KIND_CLR = 2'd2;

   // configuration register indexes
   localparam logic [2:0] CSR_TRACE_ENABLE  = 3'd0;
   localparam logic [2:0] CSR_REGION_TIMING = 3'd1;
   localparam logic [2:0] CSR_WAIT_CONTROL  = 3'd2;
   localparam logic [2:0] CSR_SEQ_CYCLES    = 3'd3;
   localparam logic [2:0] CSR_NONSEQ_CYCLES = 3'd4;

   // memory regions
   localparam logic [3:0] RGN_BIOS    = 4'd0;
   localparam logic [3:0] RGN_EWRAM   = 4'd1;
   localparam logic [3:0] RGN_IWRAM   = 4'd2;
   localparam logic [3:0] RGN_IO      = 4'd3;
   localparam logic [3:0] RGN_PALETTE = 4'd4;
   localparam logic [3:0] RGN_VRAM    = 4'd5;
   localparam logic [3:0] RGN_OAM     = 4'd6;
   localparam logic [3:0] RGN_CART0   = 4'd7;
   localparam logic [3:0] RGN_CART1   = 4'd8;
   localparam logic [3:0] RGN_CART2   = 4'd9;
   localparam logic [3:0] RGN_SRAM    = 4'd10;
   localparam logic [3:0] RGN_OTHER   = 4'd11;

   typedef enum logic [1:0] {
      OP_EXT = 2'd0,
      OP_INT = 2'd1,
      OP_CLR = 2'd2
   } op_code_type;

   typedef struct packed {
      logic        trace_enable;
      logic        region_timing;
      logic [14:0] wait_control;
      logic [7:0]  seq_cycles;
      logic [7:0]  nonseq_cycles;
   } cfg_type;

   typedef struct packed {
      op_code_type code;
      logic [1:0]  access_type;
      logic [31:0] address;
      logic [2:0]  width;
      logic [3:0]  region;
      logic [3:0]  region_hi;
      logic        cart;
      logic        split;
      logic [15:0] icyc;
   } op_type;

   typedef struct packed {
      logic        is_internal;
      logic [1:0]  access_kind;
      logic [31:0] address;
      logic [2:0]  width;
      logic [3:0]  region;
      logic        sequential;
      logic [15:0] cycles;
      logic        last;
   } rec_type;

   function automatic logic [3:0] decode_region(input logic [31:0] a);
      logic [3:0] r;
      r = RGN_OTHER;
      if (a <= 32'h0000_3FFF) r = RGN_BIOS;
      else if (a >= 32'h0200_0000 && a <= 32'h0203_FFFF) r = RGN_EWRAM;
      else if (a >= 32'h0300_0000 && a <= 32'h0300_7FFF) r = RGN_IWRAM;
      else if (a >= 32'h0400_0000 && a <= 32'h0400_03FF) r = RGN_IO;
      else if (a >= 32'h0500_0000 && a <= 32'h0500_03FF) r = RGN_PALETTE;
      else if (a >= 32'h0600_0000 && a <= 32'h0601_7FFF) r = RGN_VRAM;
      else if (a >= 32'h0700_0000 && a <= 32'h0700_03FF) r = RGN_OAM;
      else if (a >= 32'h0800_0000 && a <= 32'h09FF_FFFF) r = RGN_CART0;
      else if (a >= 32'h0A00_0000 && a <= 32'h0BFF_FFFF) r = RGN_CART1;
      else if (a >= 32'h0C00_0000 && a <= 32'h0DFF_FFFF) r = RGN_CART2;
      else if (a >= 32'h0E00_0000 && a <= 32'h0E00_FFFF) r = RGN_SRAM;
      return r;
   endfunction

   function automatic logic is_cart(input logic [3:0] r);
      return r == RGN_CART0 || r == RGN_CART1 || r == RGN_CART2;
   endfunction

   function automatic logic [3:0] first_wait(input logic [1:0] code);
      logic [3:0] w;
      case (code)
         2'd0:    w = 4'd4;
         2'd1:    w = 4'd3;
         2'd2:    w = 4'd2;
         default: w = 4'd8;
      endcase
      return w;
   endfunction

endpackage

// ----- design/mawt_front.sv -----
// ----------------------------------------------------------------------------
// mawt_front
// Accepts bus events, decodes the region and classifies them into operations.
// ----------------------------------------------------------------------------
module mawt_front (
   input  mawt_pkg::cfg_type cfg,
   input  logic              req_push,
   input  logic [1:0]        req_kind,
   input  logic [1:0]        req_access_type,
   input  logic [31:0]       req_address,
   input  logic [2:0]        req_access_width,
   input  logic [15:0]       req_internal_cycles,
   input  logic              q_full,
   output logic              q_push,
   output mawt_pkg::op_type  q_op
);
   import mawt_pkg::*;

   logic        accept;
   logic [3:0]  rgn;
   logic [31:0] addr_al;
   logic        cart;

   assign accept  = req_push && !q_full;
   assign rgn     = decode_region(req_address);
   assign cart    = cfg.region_timing && is_cart(rgn);
   assign addr_al = {req_address[31:1], 1'b0};

   always_comb begin
      q_push = 1'b0;
      q_op   = '0;
      q_op.access_type = req_access_type;
      q_op.icyc        = req_internal_cycles;
      q_op.region      = rgn;
      q_op.region_hi   = decode_region(addr_al + 32'd2);
      q_op.cart        = cart;
      q_op.split       = cart && (req_access_width == 3'd4);
      q_op.address     = cart ? addr_al : req_address;
      q_op.width       = cart ? 3'd2 : req_access_width;
      case (req_kind)
         KIND_CLR: begin
            q_op.code = OP_CLR;
            q_push    = accept;
         end
         KIND_INT: begin
            q_op.code = OP_INT;
            q_push    = accept && cfg.trace_enable && (req_internal_cycles != 16'd0);
         end
         KIND_EXT: begin
            q_op.code = OP_EXT;
            q_push    = accept && cfg.trace_enable;
         end
         default: begin
            q_op.code = OP_CLR;
            q_push    = 1'b0;
         end
      endcase
   end

endmodule

// ----- design/mawt_queue.sv -----
// ----------------------------------------------------------------------------
// mawt_queue
// Short operation queue between the front and back parts.
// ----------------------------------------------------------------------------
module mawt_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mawt_pkg::op_type push_op,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output mawt_pkg::op_type head
);
   import mawt_pkg::*;

   op_type             mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_PTR_W:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full    = (count_ff == (Q_PTR_W+1)'(Q_DEPTH));
   assign valid   = (count_ff != '0);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + Q_PTR_W'(do_push);
      rd_ptr_in = rd_ptr_ff + Q_PTR_W'(do_pop);
      count_in  = count_ff + (Q_PTR_W+1)'(do_push) - (Q_PTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_op;
      end
   end

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (Q_PTR_W+1)'(Q_DEPTH))
      else $error("queue count out of range");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == (Q_PTR_W+1)'(Q_DEPTH)) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue push lost");
`endif

endmodule

// ----- design/mawt_back.sv -----
// ----------------------------------------------------------------------------
// mawt_back
// Carries out queued operations: sequential tracking, cycle cost and records.
// ----------------------------------------------------------------------------
module mawt_back (
   input  logic             clock,
   input  logic             reset,
   input  mawt_pkg::cfg_type cfg,
   input  logic             op_valid,
   input  mawt_pkg::op_type op,
   output logic             op_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output mawt_pkg::rec_type rsp_rec
);
   import mawt_pkg::*;

   logic        half_ff, half_in;
   logic        have_prev_ff, have_prev_in;
   logic [31:0] prev_addr_ff, prev_addr_in;
   logic [2:0]  prev_width_ff, prev_width_in;
   logic [3:0]  prev_rgn_ff, prev_rgn_in;

   rec_type     obuf_ff [2];
   logic        owr_ff, owr_in, ord_ff, ord_in;
   logic [1:0]  ocnt_ff, ocnt_in;

   logic        space, work, emit, out_pop;
   rec_type     rec;
   logic [31:0] addr;
   logic [3:0]  rgn;
   logic        contiguous, seq;
   logic [1:0]  win;
   logic [1:0]  fb;
   logic        sb;
   logic [15:0] cost;

   assign out_pop   = rsp_pop && (ocnt_ff != 2'd0);
   assign space     = (ocnt_ff != 2'd2) || out_pop;
   assign work      = op_valid && space;
   assign rsp_empty = (ocnt_ff == 2'd0);
   assign rsp_rec   = obuf_ff[ord_ff];

   // both halves of a cartridge word keep the region of the access
   assign addr = half_ff ? op.address + 32'd2 : op.address;
   assign rgn  = op.region;
   assign contiguous = have_prev_ff && (rgn == prev_rgn_ff) &&
                       (addr == prev_addr_ff + {29'd0, prev_width_ff});
   assign seq = (!op.cart || (addr[16:0] != 17'd0)) && (half_ff || contiguous);

   // cartridge window index and its waitstate fields
   always_comb begin
      win = 2'd0;
      fb  = 2'd0;
      sb  = 1'b0;
      case (rgn)
         RGN_CART0: begin
            win = 2'd0;
            fb  = cfg.wait_control[3:2];
            sb  = cfg.wait_control[4];
         end
         RGN_CART1: begin
            win = 2'd1;
            fb  = cfg.wait_control[6:5];
            sb  = cfg.wait_control[7];
         end
         RGN_CART2: begin
            win = 2'd2;
            fb  = cfg.wait_control[9:8];
            sb  = cfg.wait_control[10];
         end
         default: begin
            win = 2'd0;
            fb  = 2'd0;
            sb  = 1'b0;
         end
      endcase
   end

   always_comb begin
      cost = seq ? {8'd0, cfg.seq_cycles} : {8'd0, cfg.nonseq_cycles};
      if (cfg.region_timing) begin
         case (rgn)
            RGN_BIOS, RGN_IWRAM, RGN_IO: cost = 16'd1;
            RGN_EWRAM: cost = (op.width == 3'd4) ? 16'd6 : 16'd3;
            RGN_PALETTE, RGN_VRAM, RGN_OAM: cost = (op.width == 3'd4) ? 16'd2 : 16'd1;
            RGN_CART0, RGN_CART1, RGN_CART2: begin
               if (!seq)     cost = 16'd1 + {12'd0, first_wait(fb)};
               else if (sb)  cost = 16'd2;
               else          cost = 16'd1 + (16'd2 << win);
            end
            RGN_SRAM: cost = 16'd1 + {12'd0, first_wait(cfg.wait_control[1:0])};
            default: cost = seq ? {8'd0, cfg.seq_cycles} : {8'd0, cfg.nonseq_cycles};
         endcase
      end
   end

   always_comb begin
      half_in       = half_ff;
      have_prev_in  = have_prev_ff;
      prev_addr_in  = prev_addr_ff;
      prev_width_in = prev_width_ff;
      prev_rgn_in   = prev_rgn_ff;
      op_pop        = 1'b0;
      emit          = 1'b0;
      rec           = '0;
      case (op.code)
         OP_CLR: begin
            if (work) begin
               op_pop        = 1'b1;
               have_prev_in  = 1'b0;
               prev_addr_in  = '0;
               prev_width_in = '0;
               prev_rgn_in   = RGN_BIOS;
            end
         end
         OP_INT: begin
            rec.is_internal = 1'b1;
            rec.region      = RGN_OTHER;
            rec.cycles      = op.icyc;
            rec.last        = 1'b1;
            if (work) begin
               op_pop = 1'b1;
               emit   = 1'b1;
            end
         end
         OP_EXT: begin
            rec.access_kind = op.access_type;
            rec.address     = addr;
            rec.width       = op.width;
            rec.region      = rgn;
            rec.sequential  = seq;
            rec.cycles      = cost;
            rec.last        = half_ff || !op.split;
            if (work) begin
               emit          = 1'b1;
               have_prev_in  = 1'b1;
               prev_addr_in  = addr;
               prev_width_in = op.width;
               // tracked region is the decode of the tracked address
               prev_rgn_in   = half_ff ? op.region_hi : rgn;
               op_pop        = rec.last;
               half_in       = !rec.last;
            end
         end
         default: begin
            if (work) begin
               op_pop = 1'b1;
            end
         end
      endcase
   end

   always_comb begin
      owr_in  = owr_ff ^ emit;
      ord_in  = ord_ff ^ out_pop;
      ocnt_in = ocnt_ff + {1'b0, emit} - {1'b0, out_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff       <= 1'b0;
         have_prev_ff  <= 1'b0;
         prev_addr_ff  <= '0;
         prev_width_ff <= '0;
         prev_rgn_ff   <= RGN_BIOS;
         owr_ff        <= 1'b0;
         ord_ff        <= 1'b0;
         ocnt_ff       <= '0;
      end else begin
         half_ff       <= half_in;
         have_prev_ff  <= have_prev_in;
         prev_addr_ff  <= prev_addr_in;
         prev_width_ff <= prev_width_in;
         prev_rgn_ff   <= prev_rgn_in;
         owr_ff        <= owr_in;
         ord_ff        <= ord_in;
         ocnt_ff       <= ocnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         obuf_ff[owr_ff] <= rec;
      end
   end

`ifndef ASSERT_OFF
   a_ocnt_range: assert property (@(posedge clock) disable iff (reset)
      ocnt_ff <= 2'd2)
      else $error("result buffer overflow");
   a_half_has_op: assert property (@(posedge clock) disable iff (reset)
      half_ff |-> (op_valid && op.code == OP_EXT && op.split))
      else $error("second half without a split operation");
   a_clear_tracking: assert property (@(posedge clock) disable iff (reset)
      (work && op.code == OP_CLR) |=> !have_prev_ff)
      else $error("clear did not reset tracking");
   a_second_half_seq_last: assert property (@(posedge clock) disable iff (reset)
      (emit && half_ff) |-> rec.last)
      else $error("second half not marked last");
`endif

endmodule

// ----- design/memory_access_wait_timing_unit.sv -----
// ----------------------------------------------------------------------------
// memory_access_wait_timing_unit
// Bus access timing unit: turns CPU bus events into timing records.
// ----------------------------------------------------------------------------
// usage
//   req channel: push an event while full is low; kind selects external access,
//   internal cycles or clear of the previous-access tracking
//   rsp channel: while empty is low the oldest record is on the rsp_ ports;
//   pop takes it; last marks the final record of one transaction
//   csr port: single-cycle writes, only while the block is idle
//   an accepted transaction goes into the queue, the back part then writes its
//   record into the output buffer once there is space, and pop takes it there
//   throughput: one transaction per cycle while full is low; a cartridge word
//   access under region timing gives two records and holds the back part until
//   its second half is out, as the record stage emits one record at a time
//   a four-entry queue parts the front and back, a two-entry buffer the output
//   reset: queues empty, tracking cleared, seq and nonseq costs at one,
//   tracing off
//   when the receiver stalls the buffers fill and full rises; nothing is lost
// ----------------------------------------------------------------------------
module memory_access_wait_timing_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_kind,
   input  logic [1:0]  req_access_type,
   input  logic [31:0] req_address,
   input  logic [2:0]  req_access_width,
   input  logic [15:0] req_internal_cycles,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_is_internal,
   output logic [1:0]  rsp_access_kind_out,
   output logic [31:0] rsp_record_address,
   output logic [2:0]  rsp_record_width,
   output logic [3:0]  rsp_region,
   output logic        rsp_sequential,
   output logic [15:0] rsp_cycles,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [14:0] csr_wdata
);
   import mawt_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    q_push, q_full, q_valid, q_pop;
   op_type  q_in_op, q_head;
   rec_type rec;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_TRACE_ENABLE:  cfg_in.trace_enable  = csr_wdata[0];
            CSR_REGION_TIMING: cfg_in.region_timing = csr_wdata[0];
            CSR_WAIT_CONTROL:  cfg_in.wait_control  = csr_wdata;
            CSR_SEQ_CYCLES:    cfg_in.seq_cycles    = csr_wdata[7:0];
            CSR_NONSEQ_CYCLES: cfg_in.nonseq_cycles = csr_wdata[7:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trace_enable  <= 1'b0;
         cfg_ff.region_timing <= 1'b0;
         cfg_ff.wait_control  <= '0;
         cfg_ff.seq_cycles    <= 8'd1;
         cfg_ff.nonseq_cycles <= 8'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign full = q_full;

   mawt_front u_front (
      .cfg                 (cfg_ff),
      .req_push            (push),
      .req_kind            (req_kind),
      .req_access_type     (req_access_type),
      .req_address         (req_address),
      .req_access_width    (req_access_width),
      .req_internal_cycles (req_internal_cycles),
      .q_full              (q_full),
      .q_push              (q_push),
      .q_op                (q_in_op)
   );

   mawt_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .push_op (q_in_op),
      .full    (q_full),
      .pop     (q_pop),
      .valid   (q_valid),
      .head    (q_head)
   );

   mawt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .op_valid  (q_valid),
      .op        (q_head),
      .op_pop    (q_pop),
      .rsp_empty (empty),
      .rsp_pop   (pop),
      .rsp_rec   (rec)
   );

   assign rsp_is_internal     = rec.is_internal;
   assign rsp_access_kind_out = rec.access_kind;
   assign rsp_record_address  = rec.address;
   assign rsp_record_width    = rec.width;
   assign rsp_region          = rec.region;
   assign rsp_sequential      = rec.sequential;
   assign rsp_cycles          = rec.cycles;
   assign rsp_last            = rec.last;

endmodule

// ----- sim/tb_memory_access_wait_timing_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_memory_access_wait_timing_unit
// Self-checking bench for the bus access timing unit. A directed table covers
// field extremes, every event kind, cartridge splits, boundaries and address
// wrap. Random bursts of contiguous accesses follow under changing register
// settings. Every record is checked against a cycle-cost predictor or a fixed
// expected record, with random stalls on both sides and one long receiver hold.
// ----------------------------------------------------------------------------
module tb_memory_access_wait_timing_unit;
   import mawt_pkg::*;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int LIMIT_CYCLES = 500000;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  atype;
      logic [31:0] addr;
      logic [2:0]  width;
      logic [15:0] icyc;
   } bus_event_type;

   typedef struct {
      bit            is_cfg;
      cfg_type       cfg;
      bus_event_type ev;
      bit            fixed;
      int            fixed_n;
      rec_type       fixed_rec;
   } plan_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [1:0]  req_kind = '0;
   logic [1:0]  req_access_type = '0;
   logic [31:0] req_address = '0;
   logic [2:0]  req_access_width = '0;
   logic [15:0] req_internal_cycles = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic        rsp_is_internal;
   logic [1:0]  rsp_access_kind_out;
   logic [31:0] rsp_record_address;
   logic [2:0]  rsp_record_width;
   logic [3:0]  rsp_region;
   logic        rsp_sequential;
   logic [15:0] rsp_cycles;
   logic        rsp_last;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [14:0] csr_wdata = '0;

   // predictor state and register copy
   cfg_type     cfg_model = '{1'b0, 1'b0, 15'd0, 8'd1, 8'd1};
   logic        trk_valid = 1'b0;
   logic [31:0] trk_addr = '0;
   logic [2:0]  trk_width = '0;

   rec_type      due_records[$];
   rec_type      pred_recs[2];
   plan_row_type plan[$];
   int           mismatch_count = 0;
   int           cycle_count = 0;
   int           rx_hold = 0;
   int           rx_quiet = 0;
   int           tx_quiet = 0;

   int          burst_left = 0;
   logic [31:0] burst_addr = '0;
   logic [2:0]  burst_width = 3'd4;
   logic [1:0]  burst_atype = '0;

   memory_access_wait_timing_unit u_top (
      .clock               (clock),
      .reset               (reset),
      .push                (push),
      .full                (full),
      .req_kind            (req_kind),
      .req_access_type     (req_access_type),
      .req_address         (req_address),
      .req_access_width    (req_access_width),
      .req_internal_cycles (req_internal_cycles),
      .empty               (empty),
      .pop                 (pop),
      .rsp_is_internal     (rsp_is_internal),
      .rsp_access_kind_out (rsp_access_kind_out),
      .rsp_record_address  (rsp_record_address),
      .rsp_record_width    (rsp_record_width),
      .rsp_region          (rsp_region),
      .rsp_sequential      (rsp_sequential),
      .rsp_cycles          (rsp_cycles),
      .rsp_last            (rsp_last),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor
   function automatic logic [3:0] map_region(input logic [31:0] a);
      case (a[31:24])
         8'h00:        return (a[23:14] == '0) ? RGN_BIOS : RGN_OTHER;
         8'h02:        return (a[23:18] == '0) ? RGN_EWRAM : RGN_OTHER;
         8'h03:        return (a[23:15] == '0) ? RGN_IWRAM : RGN_OTHER;
         8'h04:        return (a[23:10] == '0) ? RGN_IO : RGN_OTHER;
         8'h05:        return (a[23:10] == '0) ? RGN_PALETTE : RGN_OTHER;
         8'h06:        return (a[23:0] < 24'h01_8000) ? RGN_VRAM : RGN_OTHER;
         8'h07:        return (a[23:10] == '0) ? RGN_OAM : RGN_OTHER;
         8'h08, 8'h09: return RGN_CART0;
         8'h0A, 8'h0B: return RGN_CART1;
         8'h0C, 8'h0D: return RGN_CART2;
         8'h0E:        return (a[23:16] == '0) ? RGN_SRAM : RGN_OTHER;
         default:      return RGN_OTHER;
      endcase
   endfunction

   function automatic int first_access_wait(input logic [1:0] code);
      case (code)
         2'd0:    return 4;
         2'd1:    return 3;
         2'd2:    return 2;
         default: return 8;
      endcase
   endfunction

   function automatic logic [15:0] transfer_cost(input logic [3:0] rgn, input logic seq,
                                                 input logic [2:0] width);
      int w;
      logic [15:0] flat;
      flat = seq ? {8'd0, cfg_model.seq_cycles} : {8'd0, cfg_model.nonseq_cycles};
      if (!cfg_model.region_timing) return flat;
      case (rgn)
         RGN_BIOS, RGN_IWRAM, RGN_IO:      return 16'd1;
         RGN_EWRAM:                        return (width == 3'd4) ? 16'd6 : 16'd3;
         RGN_PALETTE, RGN_VRAM, RGN_OAM:   return (width == 3'd4) ? 16'd2 : 16'd1;
         RGN_CART0, RGN_CART1, RGN_CART2: begin
            w = int'(rgn) - int'(RGN_CART0);
            if (seq)
               return cfg_model.wait_control[4 + 3 * w] ? 16'd2 : 16'(1 + (2 << w));
            return 16'(1 + first_access_wait(cfg_model.wait_control[2 + 3 * w +: 2]));
         end
         RGN_SRAM: return 16'(1 + first_access_wait(cfg_model.wait_control[1:0]));
         default:  return flat;
      endcase
   endfunction

   function automatic rec_type bus_transfer(input logic [1:0] atype, input logic [31:0] addr,
                                            input logic [2:0] width, input logic [3:0] rgn,
                                            input logic forced);
      rec_type r;
      logic cart, contig, seq;
      logic [31:0] next_addr;
      cart = cfg_model.region_timing && rgn >= RGN_CART0 && rgn <= RGN_CART2;
      next_addr = trk_addr + {29'd0, trk_width};
      contig = trk_valid && rgn == map_region(trk_addr) && addr == next_addr;
      seq = (!cart || addr[16:0] != '0) && (forced || contig);
      r.is_internal = 1'b0;
      r.access_kind = atype;
      r.address = addr;
      r.width = width;
      r.region = rgn;
      r.sequential = seq;
      r.cycles = transfer_cost(rgn, seq, width);
      r.last = 1'b0;
      trk_valid = 1'b1;
      trk_addr = addr;
      trk_width = width;
      return r;
   endfunction

   // fills pred_recs and returns how many records the event causes
   function automatic int time_bus_event(input bus_event_type ev);
      logic [3:0] rgn;
      logic [31:0] a0;
      int n;
      if (ev.kind == KIND_CLR) begin
         trk_valid = 1'b0;
         trk_addr = '0;
         trk_width = '0;
         return 0;
      end
      if (ev.kind == KIND_UNUSED || !cfg_model.trace_enable) return 0;
      if (ev.kind == KIND_INT) begin
         if (ev.icyc == '0) return 0;
         pred_recs[0] = {1'b1, 2'd0, 32'd0, 3'd0, RGN_OTHER, 1'b0, ev.icyc, 1'b1};
         return 1;
      end
      rgn = map_region(ev.addr);
      if (cfg_model.region_timing && rgn >= RGN_CART0 && rgn <= RGN_CART2) begin
         // 16-bit bus: halfword aligned, words go out as two halves
         a0 = {ev.addr[31:1], 1'b0};
         pred_recs[0] = bus_transfer(ev.atype, a0, 3'd2, rgn, 1'b0);
         n = 1;
         if (ev.width == 3'd4) begin
            pred_recs[1] = bus_transfer(ev.atype, a0 + 32'd2, 3'd2, rgn, 1'b1);
            n = 2;
         end
      end else begin
         pred_recs[0] = bus_transfer(ev.atype, ev.addr, ev.width, rgn, 1'b0);
         n = 1;
      end
      pred_recs[n - 1].last = 1'b1;
      return n;
   endfunction

   // ---------------------------------------------------------------- checking
   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : record_check
      rec_type want;
      if (!reset && pop && !empty) begin
         if (due_records.size() == 0) begin
            $error("record with none expected: address %0h", rsp_record_address);
            mismatch_count++;
         end else begin
            want = due_records.pop_front();
            check_field("is_internal", 32'(want.is_internal), 32'(rsp_is_internal));
            check_field("access_kind_out", 32'(want.access_kind),
                        32'(rsp_access_kind_out));
            check_field("record_address", want.address, rsp_record_address);
            check_field("record_width", 32'(want.width), 32'(rsp_record_width));
            check_field("region", 32'(want.region), 32'(rsp_region));
            check_field("sequential", 32'(want.sequential), 32'(rsp_sequential));
            check_field("cycles", 32'(want.cycles), 32'(rsp_cycles));
            check_field("last", 32'(want.last), 32'(rsp_last));
         end
      end
   end

   // ---------------------------------------------------------------- receiver
   initial begin : record_sink
      int stall;
      while (reset) @(negedge clock);
      forever begin
         if (rx_hold > 0) begin
            stall = rx_hold;
            rx_hold = 0;
         end else if (rx_quiet > 0) begin
            stall = 0;
            rx_quiet--;
         end else begin
            stall = $urandom_range(0, 12);
            if ($urandom_range(0, 24) == 0) rx_quiet = $urandom_range(10, 40);
         end
         if (stall > 0) begin
            pop <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
         @(negedge clock);
      end
   end

   // ---------------------------------------------------------------- stimulus
   function automatic bus_event_type mk_event(input logic [1:0] kind,
                                              input logic [1:0] atype,
                                              input logic [31:0] addr,
                                              input logic [2:0] width,
                                              input logic [15:0] icyc);
      bus_event_type e;
      e.kind = kind;
      e.atype = atype;
      e.addr = addr;
      e.width = width;
      e.icyc = icyc;
      return e;
   endfunction

   function automatic rec_type mk_rec(input logic is_int, input logic [1:0] kind,
                                      input logic [31:0] addr, input logic [2:0] width,
                                      input logic [3:0] rgn, input logic seq,
                                      input logic [15:0] cyc, input logic last);
      return {is_int, kind, addr, width, rgn, seq, cyc, last};
   endfunction

   function automatic cfg_type mk_cfg(input logic trace, input logic rt,
                                      input logic [14:0] wc, input logic [7:0] sc,
                                      input logic [7:0] nc);
      cfg_type c;
      c.trace_enable = trace;
      c.region_timing = rt;
      c.wait_control = wc;
      c.seq_cycles = sc;
      c.nonseq_cycles = nc;
      return c;
   endfunction

   function automatic void plan_cfg(input cfg_type c);
      plan_row_type row;
      row = '{1'b1, c, '0, 1'b0, 0, '0};
      plan.insert(plan.size(), row);
   endfunction

   function automatic void plan_fixed(input bus_event_type e, input int n, input rec_type r);
      plan_row_type row;
      row = '{1'b0, '0, e, 1'b1, n, r};
      plan.insert(plan.size(), row);
   endfunction

   function automatic void plan_event(input bus_event_type e);
      plan_row_type row;
      row = '{1'b0, '0, e, 1'b0, 0, '0};
      plan.insert(plan.size(), row);
   endfunction

   function automatic logic [31:0] pick_address();
      logic [31:0] off, base;
      int sel;
      off = $urandom;
      sel = $urandom_range(0, 12);
      case (sel)
         0:  return off & 32'h3FFF;
         1:  return 32'h0200_0000 | (off & 32'h3_FFFF);
         2:  return 32'h0300_0000 | (off & 32'h7FFF);
         3:  return 32'h0400_0000 | (off & 32'h3FF);
         4:  return 32'h0500_0000 | (off & 32'h3FF);
         5:  return 32'h0600_0000 + (off % 32'h1_8000);
         6:  return 32'h0700_0000 | (off & 32'h3FF);
         7, 8, 9: begin
            base = 32'h0800_0000 + 32'(sel - 7) * 32'h0200_0000;
            // land on or just short of a 128 KiB boundary
            if ($urandom_range(0, 1) == 1)
               return base + ((off & 32'hFF) << 17) - 32'($urandom_range(0, 3)) * 32'd2;
            return base | (off & 32'h01FF_FFFF);
         end
         10: return 32'h0E00_0000 | (off & 32'hFFFF);
         11: return 32'h0E00_FFF0 + (off & 32'h1F);
         default: return off;
      endcase
   endfunction

   function automatic bus_event_type next_event();
      bus_event_type e;
      int r;
      e = mk_event(KIND_EXT, 2'($urandom), $urandom, 3'($urandom), 16'($urandom));
      r = $urandom_range(0, 99);
      if (r < 10) begin
         e.kind = KIND_INT;
         if ($urandom_range(0, 7) == 0) e.icyc = '0;
      end else if (r < 13) begin
         e.kind = KIND_CLR;
      end else if (r < 15) begin
         e.kind = KIND_UNUSED;
      end else if (r >= 20) begin
         // contiguous run; the rest of the externals are scattered noise
         if (burst_left == 0) begin
            if ($urandom_range(0, 9) == 0) burst_width = 3'($urandom_range(0, 7));
            else burst_width = 3'(1 << $urandom_range(0, 2));
            burst_addr = pick_address();
            if ($urandom_range(0, 4) != 0 && (burst_width == 3'd2 || burst_width == 3'd4))
               burst_addr = burst_addr & ~(32'(burst_width) - 32'd1);
            burst_atype = 2'($urandom);
            burst_left = $urandom_range(1, 12);
         end
         e.atype = burst_atype;
         e.addr = burst_addr;
         e.width = burst_width;
         burst_addr = burst_addr + 32'(burst_width);
         burst_left--;
      end
      return e;
   endfunction

   task automatic send_event(input bus_event_type e, input bit fixed, input int fixed_n,
                             input rec_type fixed_rec);
      int gap, n;
      if (tx_quiet > 0) begin
         gap = 0;
         tx_quiet--;
      end else begin
         gap = $urandom_range(0, 12);
         if ($urandom_range(0, 24) == 0) tx_quiet = $urandom_range(10, 40);
      end
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_kind <= e.kind;
      req_access_type <= e.atype;
      req_address <= e.addr;
      req_access_width <= e.width;
      req_internal_cycles <= e.icyc;
      push <= 1'b1;
      do @(posedge clock); while (full);
      n = time_bus_event(e);
      if (fixed) begin
         if (fixed_n > 0) due_records.insert(due_records.size(), fixed_rec);
      end else begin
         for (int i = 0; i < n; i++) due_records.insert(due_records.size(), pred_recs[i]);
      end
      @(negedge clock);
   endtask

   task automatic settle_idle();
      push <= 1'b0;
      while (due_records.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic apply_cfg(input cfg_type c);
      settle_idle();
      csr_we <= 1'b1;
      csr_index <= CSR_TRACE_ENABLE;
      csr_wdata <= {14'd0, c.trace_enable};
      @(negedge clock);
      csr_index <= CSR_REGION_TIMING;
      csr_wdata <= {14'd0, c.region_timing};
      @(negedge clock);
      csr_index <= CSR_WAIT_CONTROL;
      csr_wdata <= c.wait_control;
      @(negedge clock);
      csr_index <= CSR_SEQ_CYCLES;
      csr_wdata <= {7'd0, c.seq_cycles};
      @(negedge clock);
      csr_index <= CSR_NONSEQ_CYCLES;
      csr_wdata <= {7'd0, c.nonseq_cycles};
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_model = c;
   endtask

   initial begin : stimulus
      bus_event_type e;
      cfg_type c;
      int count, target;

      // tracing off after reset
      plan_fixed(mk_event(KIND_EXT, 2'd3, 32'hFFFF_FFFF, 3'd4, 16'hFFFF), 0, '0);
      plan_fixed(mk_event(KIND_INT, 2'd0, 32'd0, 3'd0, 16'd100), 0, '0);
      plan_fixed(mk_event(KIND_CLR, 2'd3, 32'hFFFF_FFFF, 3'd7, 16'hFFFF), 0, '0);
      plan_cfg(mk_cfg(1'b1, 1'b0, 15'd0, 8'd1, 8'd1));
      plan_fixed(mk_event(KIND_EXT, 2'd3, 32'd0, 3'd4, 16'd0), 1,
                 mk_rec(1'b0, 2'd3, 32'd0, 3'd4, RGN_BIOS, 1'b0, 16'd1, 1'b1));
      plan_event(mk_event(KIND_EXT, 2'd0, 32'd4, 3'd4, 16'd0));
      plan_fixed(mk_event(KIND_INT, 2'd0, 32'd0, 3'd0, 16'hFFFF), 1,
                 mk_rec(1'b1, 2'd0, 32'd0, 3'd0, RGN_OTHER, 1'b0, 16'hFFFF, 1'b1));
      plan_fixed(mk_event(KIND_INT, 2'd3, 32'hFFFF_FFFF, 3'd7, 16'd0), 0, '0);
      plan_fixed(mk_event(KIND_UNUSED, 2'd3, 32'hFFFF_FFFF, 3'd7, 16'hFFFF), 0, '0);
      // address wrap, zero and odd widths
      plan_event(mk_event(KIND_EXT, 2'd1, 32'hFFFF_FFFF, 3'd7, 16'd0));
      plan_event(mk_event(KIND_EXT, 2'd2, 32'd6, 3'd0, 16'd0));
      plan_event(mk_event(KIND_EXT, 2'd2, 32'd6, 3'd3, 16'd0));
      // region timing, slowest first-access waitstates, flat cost extremes
      plan_cfg(mk_cfg(1'b1, 1'b1, 15'h7FFF, 8'hFF, 8'd0));
      plan_event(mk_event(KIND_EXT, 2'd0, 32'h0800_0000, 3'd4, 16'd0));
      plan_event(mk_event(KIND_EXT, 2'd1, 32'h09FF_FFFF, 3'd4, 16'd0));
      plan_event(mk_event(KIND_EXT, 2'd2, 32'h0A02_0000, 3'd2, 16'd0));
      plan_event(mk_event(KIND_EXT, 2'd3, 32'h0DFF_FFFF, 3'd1, 16'd0));
      plan_event(mk_event(KIND_EXT, 2'd0, 32'h0E00_FFFF, 3'd1, 16'd0));
      plan_event(mk_event(KIND_EXT, 2'd0, 32'h0E01_0000, 3'd1, 16'd0));
      plan_event(mk_event(KIND_EXT, 2'd0, 32'h0200_0000, 3'd4, 16'd0));
      plan_event(mk_event(KIND_EXT, 2'd0, 32'h0200_0004, 3'd2, 16'd0));
      plan_event(mk_event(KIND_EXT, 2'd0, 32'h0601_7FFC, 3'd4, 16'd0));
      plan_event(mk_event(KIND_EXT, 2'd0, 32'h0400_0000, 3'd4, 16'd0));
      plan_cfg(mk_cfg(1'b1, 1'b1, 15'd0, 8'd0, 8'hFF));
      plan_event(mk_event(KIND_EXT, 2'd0, 32'h0C00_0010, 3'd4, 16'd0));
      plan_event(mk_event(KIND_CLR, 2'd0, 32'd0, 3'd0, 16'd0));
      plan_event(mk_event(KIND_EXT, 2'd0, 32'h0C00_0018, 3'd4, 16'd0));
      plan_event(mk_event(KIND_EXT, 2'd0, 32'h0E00_0000, 3'd1, 16'd0));

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_cfg) apply_cfg(plan[i].cfg);
         else send_event(plan[i].ev, plan[i].fixed, plan[i].fixed_n, plan[i].fixed_rec);
      end

      for (int p = 0; p < 9; p++) begin
         c.trace_enable = (p != 4);
         c.region_timing = (p % 3 != 0);
         c.wait_control = (p == 1) ? 15'd0 : (p == 2) ? 15'h7FFF : 15'($urandom);
         c.seq_cycles = (p == 5) ? 8'd0 : (p == 6) ? 8'hFF : 8'($urandom);
         c.nonseq_cycles = (p == 5) ? 8'hFF : (p == 6) ? 8'd0 : 8'($urandom);
         apply_cfg(c);
         // receiver stalls long enough for the queues to back up into full
         if (p == 2) rx_hold = 300;
         target = c.trace_enable ? 90 : 40;
         count = 0;
         while (count < target) begin
            e = next_event();
            send_event(e, 1'b0, 0, '0);
            if (e.kind != KIND_UNUSED) count++;
         end
      end

      settle_idle();
      if (mismatch_count == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

endmodule
